// File: hdl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

	// function codes of an input word
	localparam logic [1:0] FUNC_PUT   = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// configuration register indexes
	localparam logic REG_SCROLL_ENABLE = 1'b0;
	localparam logic REG_DEFAULT_COLOR = 1'b1;

	// control characters
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_FORMFEED  = 8'h0C;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;

	localparam logic [7:0] COLOR_RESET = 8'h0F;

	localparam int CELL_W = 16;

	// what one put does to the screen store
	typedef struct packed {
		logic write_cell;
		logic scroll;
	} put_flags_t;

endpackage
`default_nettype wire

// File: hdl/tcw_ram.sv
`default_nettype none
module tcw_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/tcw_cursor.sv
`default_nettype none
module tcw_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	localparam int CW = $clog2(COLUMNS),
	localparam int RW = $clog2(ROWS),
	localparam int AW = $clog2(COLUMNS * ROWS)
) (
	input  wire logic [CW-1:0]     col,
	input  wire logic [RW-1:0]     row,
	input  wire logic [7:0]        char_code,
	input  wire logic              scroll_enable,
	output logic      [CW-1:0]     col_next,
	output logic      [RW-1:0]     row_next,
	output logic      [AW-1:0]     cell_addr,
	output tcw_pkg::put_flags_t    flags
);
	import tcw_pkg::*;

	logic [CW:0] col_inc;
	logic [RW:0] row_inc;
	logic [CW:0] c_w;
	logic [RW:0] r_w;

	assign col_inc = {1'b0, col} + (CW+1)'(1);
	assign row_inc = {1'b0, row} + (RW+1)'(1);

	// cursor always stays on screen, so the address is always in range
	assign cell_addr = AW'(row) * AW'(COLUMNS) + AW'(col);

	always_comb begin
		flags = '0;
		c_w = {1'b0, col};
		r_w = {1'b0, row};
		case (char_code)
			CH_NEWLINE: begin
				c_w = '0;
				r_w = row_inc;
			end
			CH_FORMFEED: begin
				c_w = '0;
				r_w = '0;
			end
			CH_BACKSPACE: begin
				if (col == '0) begin
					if (row != '0) begin
						r_w = {1'b0, row} - (RW+1)'(1);
					end
				end else begin
					c_w = {1'b0, col} - (CW+1)'(1);
				end
			end
			default: begin
				flags.write_cell = 1'b1;
				if (col_inc == (CW+1)'(COLUMNS)) begin
					c_w = '0;
					r_w = row_inc;
				end else begin
					c_w = col_inc;
				end
			end
		endcase

		// past the last row: scroll or wrap to the top
		if (r_w == (RW+1)'(ROWS)) begin
			c_w = '0;
			if (scroll_enable) begin
				r_w = (RW+1)'(ROWS - 1);
				flags.scroll = 1'b1;
			end else begin
				r_w = '0;
			end
		end
	end

	assign col_next = c_w[CW-1:0];
	assign row_next = r_w[RW-1:0];

endmodule
`default_nettype wire

// File: hdl/text_console_writer_unit.sv
`default_nettype none
// Character-cell text console: a COLUMNS x ROWS screen of 16-bit cells
// (attribute high byte, character low byte) held in one single-port-write,
// registered-read memory, plus a cursor. A put that scrolls copies the rows
// below the top up one row through the memory, one cell per cycle, and blanks
// the bottom row; a clear makes one memory write per cell.
// After reset a clearing pass writes zero to all COLUMNS*ROWS cells, one per
// cycle, before the first word is accepted; configuration writes are taken
// throughout. An item may be accepted while the previous result is still
// waiting on the output; its own result then waits until that one is taken.
module text_console_writer_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	// input words
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  color,
	input  wire logic [10:0] cell_index,
	// result words
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      read_data,
	output logic [6:0]       cursor_col,
	output logic [4:0]       cursor_row,
	output logic             did_scroll
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam int AW = $clog2(CELLS);
	localparam logic [AW-1:0] LAST = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_END = AW'(CELLS - COLUMNS);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_FILL,
		ST_SCROLL,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	state_t state_q;

	logic              scroll_en_q;
	logic [7:0]        dcolor_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     ptr_q;
	logic [7:0]        char_q;
	logic [7:0]        color_q;
	logic              rng_q;
	logic [15:0]       res_data_q;
	logic              res_scr_q;
	logic              out_valid_q;
	logic [15:0]       read_data_q;
	logic [6:0]        cursor_col_q;
	logic [4:0]        cursor_row_q;
	logic              did_scroll_q;

	// scroll copy pipeline
	logic              wr_vld_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic              wr_src_s1;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic [CW-1:0]     col_next;
	logic [RW-1:0]     row_next;
	logic [AW-1:0]     cur_addr;
	put_flags_t        flags;

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_cursor (
		.col(col_q),
		.row(row_q),
		.char_code(char_q),
		.scroll_enable(scroll_en_q),
		.col_next(col_next),
		.row_next(row_next),
		.cell_addr(cur_addr),
		.flags(flags)
	);

	tcw_ram #(
		.DEPTH(CELLS),
		.WIDTH(CELL_W)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = '0;
			end
			ST_FILL: begin
				ram_we = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = {dcolor_q, char_q};
			end
			ST_PUT: begin
				ram_we = flags.write_cell;
				ram_waddr = cur_addr;
				ram_wdata = {color_q, char_q};
			end
			default: begin
				ram_we = wr_vld_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = wr_src_s1 ? ram_rdata : '0;
			end
		endcase
	end

	// source row is one below; writes trail reads so no hazard
	assign ram_raddr = (state_q == ST_IDLE) ? AW'(cell_index) : ptr_q + AW'(COLUMNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			scroll_en_q <= 1'b1;
			dcolor_q <= COLOR_RESET;
			col_q <= '0;
			row_q <= '0;
			ptr_q <= '0;
			wr_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			res_scr_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_SCROLL_ENABLE: scroll_en_q <= cfg_data[0];
					REG_DEFAULT_COLOR: dcolor_q <= cfg_data;
					default: ;
				endcase
			end

			wr_vld_s1 <= (state_q == ST_SCROLL);
			wr_addr_s1 <= ptr_q;
			wr_src_s1 <= (ptr_q < COPY_END);

			// load a new result word, or drop the one just taken
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						char_q <= char_code;
						color_q <= color;
						rng_q <= (32'(cell_index) < CELLS);
						res_data_q <= '0;
						res_scr_q <= 1'b0;
						ptr_q <= '0;
						case (func)
							FUNC_PUT: state_q <= ST_PUT;
							FUNC_CLEAR: state_q <= ST_FILL;
							FUNC_READ: state_q <= ST_READ;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_PUT: begin
					col_q <= col_next;
					row_q <= row_next;
					res_scr_q <= flags.scroll;
					state_q <= flags.scroll ? ST_SCROLL : ST_DONE;
				end
				ST_FILL: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCROLL: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_READ: begin
					res_data_q <= rng_q ? ram_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						read_data_q <= res_data_q;
						cursor_col_q <= 7'(col_q);
						cursor_row_q <= 5'(row_q);
						did_scroll_q <= res_scr_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign cursor_col = cursor_col_q;
	assign cursor_row = cursor_row_q;
	assign did_scroll = did_scroll_q;

endmodule
`default_nettype wire

// File: dv/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps
module text_console_writer_unit_tb;
	import tcw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int HOLD_AT = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_FROM = 800;
	localparam int QUIET_TO = 1100;
	localparam int PHASE_WORDS = 366;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		logic [15:0] data;
		logic [6:0]  col;
		logic [4:0]  row;
		logic        scrolled;
	} console_status_t;

	class screen_tracker;
		logic [15:0] cells [CELLS];
		int col;
		int row;
		bit scroll_on;
		logic [7:0] fill_color;
		console_status_t awaited[$];
		int mismatches;
		longint budget;

		function new();
			foreach (cells[i]) cells[i] = '0;
			col = 0;
			row = 0;
			scroll_on = 1'b1;
			fill_color = COLOR_RESET;
			mismatches = 0;
			budget = 0;
		endfunction

		function bit apply_put(logic [7:0] ch, logic [7:0] attr);
			bit scrolled;
			int i;
			scrolled = 1'b0;
			if (ch == CH_NEWLINE) begin
				col = 0;
				row++;
			end else if (ch == CH_FORMFEED) begin
				col = 0;
				row = 0;
			end else if (ch == CH_BACKSPACE) begin
				if (col == 0) begin
					if (row > 0) row--;
				end else begin
					col--;
				end
			end else begin
				cells[row * COLUMNS + col] = {attr, ch};
				col++;
			end
			if (col >= COLUMNS) begin
				col = 0;
				row++;
			end
			if (row >= ROWS) begin
				if (scroll_on) begin
					// move every row up one, blank the bottom row
					for (i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
					for (i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = '0;
					row = ROWS - 1;
					scrolled = 1'b1;
				end else begin
					row = 0;
				end
				col = 0;
			end
			return scrolled;
		endfunction

		function void take_word(logic [1:0] f, logic [7:0] ch, logic [7:0] attr,
				logic [10:0] idx);
			console_status_t st;
			st = '0;
			budget += 16;
			case (f)
				FUNC_PUT: begin
					st.scrolled = apply_put(ch, attr);
					if (st.scrolled) budget += 2 * CELLS;
				end
				FUNC_CLEAR: begin
					foreach (cells[i]) cells[i] = {fill_color, ch};
					budget += 2 * CELLS;
				end
				FUNC_READ: begin
					if (idx < CELLS) st.data = cells[idx];
				end
				default: ;
			endcase
			st.col = col[6:0];
			st.row = row[4:0];
			awaited.push_back(st);
		endfunction

		task report(string msg);
			if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_word(console_status_t got);
			console_status_t want;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected word data %h col %0d row %0d scroll %0b",
					got.data, got.col, got.row, got.scrolled));
				return;
			end
			want = awaited.pop_front();
			if (got.data !== want.data)
				report($sformatf("read_data %h, want %h", got.data, want.data));
			if (got.col !== want.col)
				report($sformatf("cursor_col %0d, want %0d", got.col, want.col));
			if (got.row !== want.row)
				report($sformatf("cursor_row %0d, want %0d", got.row, want.row));
			if (got.scrolled !== want.scrolled)
				report($sformatf("did_scroll %0b, want %0b", got.scrolled, want.scrolled));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	wire logic   in_ready;
	logic [1:0]  func;
	logic [7:0]  char_code;
	logic [7:0]  color;
	logic [10:0] cell_index;
	wire logic   out_valid;
	logic        out_ready;
	wire logic [15:0] read_data;
	wire logic [6:0]  cursor_col;
	wire logic [4:0]  cursor_row;
	wire logic        did_scroll;

	screen_tracker book = new();
	int words_sent = 0;
	int results_seen = 0;

	text_console_writer_unit #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.char_code(char_code),
		.color(color),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.did_scroll(did_scroll)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic set_console_mode(input bit scroll, input logic [7:0] fill);
		cfg_wen <= 1'b1;
		cfg_index <= REG_SCROLL_ENABLE;
		cfg_data <= {7'd0, scroll};
		@(posedge clk);
		cfg_index <= REG_DEFAULT_COLOR;
		cfg_data <= fill;
		@(posedge clk);
		cfg_wen <= 1'b0;
		book.scroll_on = scroll;
		book.fill_color = fill;
	endtask

	task automatic send_word(input logic [1:0] f, input logic [7:0] ch,
			input logic [7:0] attr, input logic [10:0] idx);
		in_valid <= 1'b1;
		func <= f;
		char_code <= ch;
		color <= attr;
		cell_index <= idx;
		do @(posedge clk); while (!in_ready);
		book.take_word(f, ch, attr, idx);
		words_sent++;
	endtask

	task automatic pause_sender();
		if (words_sent < QUIET_FROM || words_sent >= QUIET_TO) begin
			if ($urandom_range(99) < 25) begin
				in_valid <= 1'b0;
				do @(posedge clk); while ($urandom_range(99) < 25);
			end
		end
	endtask

	// wait out every pending result with no word on offer
	task automatic drain();
		in_valid <= 1'b0;
		while (book.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_random_word(input int nl_w, input int ff_w);
		int r;
		logic [1:0] f;
		logic [7:0] ch;
		logic [10:0] idx;
		r = $urandom_range(99);
		f = FUNC_PUT;
		ch = 8'($urandom_range(255));
		idx = 11'($urandom_range(2047));
		if (r < nl_w) begin
			ch = CH_NEWLINE;
		end else if (r < nl_w + ff_w) begin
			ch = CH_FORMFEED;
		end else if (r < nl_w + ff_w + 6) begin
			ch = CH_BACKSPACE;
		end else if (r < nl_w + ff_w + 28) begin
			f = FUNC_READ;
			// half the reads look at the cursor's row, where the latest text lands
			if ($urandom_range(1))
				idx = 11'(book.row * COLUMNS + $urandom_range(COLUMNS - 1));
		end else if (r < nl_w + ff_w + 29) begin
			f = FUNC_CLEAR;
		end else if (r < nl_w + ff_w + 31) begin
			f = FUNC_UNUSED;
		end
		pause_sender();
		send_word(f, ch, 8'($urandom_range(255)), idx);
	endtask

	task automatic run_phase(input bit scroll, input logic [7:0] fill, input int nl_w,
			input int ff_w);
		int n;
		n = 0;
		set_console_mode(scroll, fill);
		while (n < PHASE_WORDS) begin
			if ($urandom_range(149) == 0) begin
				// a long line: wraps at the row end; on the last row scrolls, or wraps to the top with scrolling off
				repeat ($urandom_range(80, 90)) begin
					pause_sender();
					send_word(FUNC_PUT, 8'($urandom_range(16, 255)), 8'($urandom_range(255)),
						11'($urandom_range(2047)));
					n++;
				end
			end else begin
				send_random_word(nl_w, ff_w);
				n++;
			end
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= REG_SCROLL_ENABLE;
		cfg_data <= 8'd0;
		in_valid <= 1'b0;
		func <= FUNC_PUT;
		char_code <= 8'd0;
		color <= 8'd0;
		cell_index <= 11'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_console_mode(1'b1, COLOR_RESET);

		send_word(FUNC_READ, 8'h00, 8'h00, 11'd0);
		send_word(FUNC_READ, 8'hFF, 8'hFF, 11'd1999);
		send_word(FUNC_READ, 8'h00, 8'h00, 11'd2000);
		send_word(FUNC_READ, 8'h00, 8'h00, 11'd2047);
		send_word(FUNC_PUT, 8'h41, 8'hFF, 11'd0);
		send_word(FUNC_PUT, 8'h00, 8'h00, 11'd0);
		send_word(FUNC_PUT, 8'hFF, 8'hA5, 11'd2047);
		send_word(FUNC_PUT, CH_BACKSPACE, 8'h00, 11'd0);
		send_word(FUNC_READ, 8'h00, 8'h00, 11'd0);
		send_word(FUNC_READ, 8'h00, 8'h00, 11'd2);
		send_word(FUNC_PUT, CH_NEWLINE, 8'h00, 11'd0);
		send_word(FUNC_PUT, CH_BACKSPACE, 8'h00, 11'd0);
		send_word(FUNC_PUT, CH_BACKSPACE, 8'h00, 11'd0);
		send_word(FUNC_PUT, 8'h7E, 8'h12, 11'd0);
		send_word(FUNC_PUT, CH_FORMFEED, 8'h00, 11'd0);
		send_word(FUNC_UNUSED, 8'hFF, 8'hFF, 11'd2047);
		send_word(FUNC_CLEAR, 8'h20, 8'h00, 11'd0);
		send_word(FUNC_READ, 8'h00, 8'h00, 11'd1999);
		send_word(FUNC_PUT, 8'h80, 8'h5A, 11'd0);
		send_word(FUNC_READ, 8'h00, 8'h00, 11'd0);
		drain();

		run_phase(1'b1, COLOR_RESET, 10, 1);
		run_phase(1'b0, 8'h00, 10, 2);
		run_phase(1'b1, 8'hFF, 6, 3);
		run_phase(1'b0, 8'($urandom_range(255)), 8, 2);
		run_phase(1'b1, 8'($urandom_range(255)), 10, 1);

		if (book.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		console_status_t got;
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {read_data, cursor_col, cursor_row, did_scroll};
				book.check_word(got);
				results_seen++;
			end
			if (results_seen >= HOLD_AT && !held) begin
				// hold off so the block backs up and stalls its input
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 25);
			end
		end
	end

	initial begin
		longint cycles;
		cycles = 0;
		// the limit grows with the work of every accepted word
		while (cycles < 4 * book.budget + 40000) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_cursor.sv
hdl/text_console_writer_unit.sv
dv/text_console_writer_unit_tb.sv
